### hdl/cvsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cell voltage summary frame - shared definitions
// Sizes, register map codes, reciprocal constants and the position label ROM.
// ----------------------------------------------------------------------------
package cvsf_pkg;

    // Pack geometry
    localparam logic [2:0] STACKS            = 3'd3;
    localparam logic [4:0] MODULES_PER_STACK = 5'd12;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_PACK_FLOOR   = 2'd0;
    localparam logic [1:0] REG_PACK_CEILING = 2'd1;
    localparam logic [1:0] REG_CELL_FLOOR   = 2'd2;
    localparam logic [1:0] REG_CELL_CEILING = 2'd3;

    // Reset values
    localparam logic [15:0] NO_VOLTAGE_LOW    = 16'hFFFF;
    localparam logic [15:0] PACK_CEILING_INIT = 16'hFFFF;
    localparam logic [7:0]  CELL_CEILING_INIT = 8'hFF;

    // raw / 10000 = (raw >> 4) / 625 ; 28-bit dividend, shift 38
    localparam logic [28:0] PACK_RECIP = 29'd439804652;
    localparam int          PACK_SHIFT = 38;
    // raw / 1000 = (raw >> 3) / 125 ; 13-bit dividend, shift 20
    localparam logic [13:0] CELL_RECIP = 14'd8389;
    localparam int          CELL_SHIFT = 20;

    // Snapshot of one scan, taken on the last reading
    typedef struct packed {
        logic [15:0] lowest;
        logic [15:0] highest;
        logic [1:0]  low_stack;
        logic [3:0]  low_module;
        logic [1:0]  high_stack;
        logic [3:0]  high_module;
        logic [18:0] pack_q;
    } t_snapshot;

    typedef logic [7:0] t_label_row [12];

    localparam t_label_row LABEL_ROW0 = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd91,
                                          8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd92};
    localparam t_label_row LABEL_ROW1 = '{8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd93,
                                          8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd94};
    localparam t_label_row LABEL_ROW2 = '{8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26,
                                          8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32};

    // Position to channel label; unmapped positions give zero
    function automatic logic [7:0] label_of(input logic [1:0] stack,
                                            input logic [3:0] module_idx);
        logic [7:0] label;
        label = 8'd0;
        if (module_idx < 4'd12) begin
            unique case (stack)
                2'd0:    label = LABEL_ROW0[module_idx];
                2'd1:    label = LABEL_ROW1[module_idx];
                2'd2:    label = LABEL_ROW2[module_idx];
                default: label = 8'd0;
            endcase
        end
        return label;
    endfunction

endpackage
`default_nettype wire

### hdl/cell_voltage_summary_frame_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cell voltage summary frame unit
// Tracks cell voltage extremes over a scan and emits one clamped summary
// frame on the last reading.
// ----------------------------------------------------------------------------
// One cell reading is taken every clock cycle; busy stays low. The frame
// for a scan is on o_valid for a single cycle, once the reading marked
// last has passed through the pipeline; the receiver must take it then.
// Three register stages lie between the two: input
// capture, running min/max update with the pack voltage reciprocal multiply,
// then cell scaling, clamping and labels.
// The running compare is the loop that fixes the rate of one
// reading per cycle. Configuration is taken over APB with no wait states.
module cell_voltage_summary_frame_unit
    import cvsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_cell_raw_voltage,
    input  wire logic        i_cell_enabled,
    input  wire logic [1:0]  i_stack_index,
    input  wire logic [3:0]  i_module_index,
    input  wire logic        i_last_cell,
    input  wire logic [31:0] i_pack_raw_voltage,
    // result channel
    output logic             o_valid,
    output logic [15:0]      o_pack_volts,
    output logic [7:0]       o_min_cell_decivolts,
    output logic [7:0]       o_min_cell_label,
    output logic [7:0]       o_max_cell_decivolts,
    output logic [7:0]       o_max_cell_label,
    output logic             o_bounds_flag,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [15:0] r_pack_floor;
    logic [15:0] r_pack_ceiling;
    logic [7:0]  r_cell_floor;
    logic [7:0]  r_cell_ceiling;

    // input stage
    logic        r_in_valid;
    logic [15:0] r_in_voltage;
    logic        r_in_enabled;
    logic [1:0]  r_in_stack;
    logic [3:0]  r_in_module;
    logic        r_in_last;
    logic [31:0] r_in_pack;

    // running scan state
    logic [15:0] r_lowest, n_lowest;
    logic [15:0] r_highest, n_highest;
    logic [1:0]  r_low_stack, n_low_stack;
    logic [3:0]  r_low_module, n_low_module;
    logic [1:0]  r_high_stack, n_high_stack;
    logic [3:0]  r_high_module, n_high_module;

    // snapshot stage
    logic        r_snap_valid;
    t_snapshot   r_snap, n_snap;

    // result stage
    logic        r_out_valid;
    logic [15:0] r_out_pack, n_out_pack;
    logic [7:0]  r_out_min, n_out_min;
    logic [7:0]  r_out_min_label;
    logic [7:0]  r_out_max, n_out_max;
    logic [7:0]  r_out_max_label;
    logic        r_out_flag, n_out_flag;

    logic        track;
    logic        frame_end;
    logic [56:0] pack_prod;
    logic [26:0] low_prod;
    logic [26:0] high_prod;
    logic [6:0]  low_q;
    logic [6:0]  high_q;
    logic        cfg_write;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // ---------------- configuration ----------------
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_floor   <= 16'd0;
            r_pack_ceiling <= PACK_CEILING_INIT;
            r_cell_floor   <= 8'd0;
            r_cell_ceiling <= CELL_CEILING_INIT;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_PACK_FLOOR:   r_pack_floor   <= pwdata[15:0];
                REG_PACK_CEILING: r_pack_ceiling <= pwdata[15:0];
                REG_CELL_FLOOR:   r_cell_floor   <= pwdata[7:0];
                REG_CELL_CEILING: r_cell_ceiling <= pwdata[7:0];
                default:          r_cell_ceiling <= r_cell_ceiling;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PACK_FLOOR:   prdata = {16'd0, r_pack_floor};
            REG_PACK_CEILING: prdata = {16'd0, r_pack_ceiling};
            REG_CELL_FLOOR:   prdata = {24'd0, r_cell_floor};
            REG_CELL_CEILING: prdata = {24'd0, r_cell_ceiling};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_voltage <= i_cell_raw_voltage;
        r_in_enabled <= i_cell_enabled;
        r_in_stack   <= i_stack_index;
        r_in_module  <= i_module_index;
        r_in_last    <= i_last_cell;
        r_in_pack    <= i_pack_raw_voltage;
    end

    // ---------------- running min/max ----------------
    // out-of-range positions take no part in tracking
    assign track = r_in_valid && r_in_enabled
                   && ({1'b0, r_in_stack} < STACKS)
                   && ({1'b0, r_in_module} < MODULES_PER_STACK);
    assign frame_end = r_in_valid && r_in_last;
    assign pack_prod = 57'(r_in_pack[31:4]) * 57'(PACK_RECIP);

    always_comb begin
        n_lowest      = r_lowest;
        n_low_stack   = r_low_stack;
        n_low_module  = r_low_module;
        n_highest     = r_highest;
        n_high_stack  = r_high_stack;
        n_high_module = r_high_module;
        // strict compares keep the first cell on ties
        if (track && (r_in_voltage < r_lowest)) begin
            n_lowest     = r_in_voltage;
            n_low_stack  = r_in_stack;
            n_low_module = r_in_module;
        end
        if (track && (r_in_voltage > r_highest)) begin
            n_highest     = r_in_voltage;
            n_high_stack  = r_in_stack;
            n_high_module = r_in_module;
        end
        n_snap.lowest      = n_lowest;
        n_snap.highest     = n_highest;
        n_snap.low_stack   = n_low_stack;
        n_snap.low_module  = n_low_module;
        n_snap.high_stack  = n_high_stack;
        n_snap.high_module = n_high_module;
        n_snap.pack_q      = pack_prod[PACK_SHIFT +: 19];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_end) begin
            // frame taken: start the next scan afresh
            r_lowest      <= NO_VOLTAGE_LOW;
            r_highest     <= 16'd0;
            r_low_stack   <= 2'd0;
            r_low_module  <= 4'd0;
            r_high_stack  <= 2'd0;
            r_high_module <= 4'd0;
        end else begin
            r_lowest      <= n_lowest;
            r_highest     <= n_highest;
            r_low_stack   <= n_low_stack;
            r_low_module  <= n_low_module;
            r_high_stack  <= n_high_stack;
            r_high_module <= n_high_module;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else begin
            r_snap_valid <= frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_snap <= n_snap;
        end
    end

    // ---------------- scaling, clamping, labels ----------------
    assign low_prod  = 27'(r_snap.lowest[15:3]) * 27'(CELL_RECIP);
    assign high_prod = 27'(r_snap.highest[15:3]) * 27'(CELL_RECIP);
    assign low_q     = low_prod[CELL_SHIFT +: 7];
    assign high_q    = high_prod[CELL_SHIFT +: 7];

    always_comb begin
        n_out_flag = 1'b0;

        // floor first; floor > ceiling: under floor gets floor, else ceiling
        if (r_snap.pack_q < {3'd0, r_pack_floor}) begin
            n_out_pack = r_pack_floor;
            n_out_flag = 1'b1;
        end else if (r_snap.pack_q > {3'd0, r_pack_ceiling}) begin
            n_out_pack = r_pack_ceiling;
            n_out_flag = 1'b1;
        end else begin
            n_out_pack = r_snap.pack_q[15:0];
        end

        if ({1'b0, low_q} < r_cell_floor) begin
            n_out_min  = r_cell_floor;
            n_out_flag = 1'b1;
        end else if ({1'b0, low_q} > r_cell_ceiling) begin
            n_out_min  = r_cell_ceiling;
            n_out_flag = 1'b1;
        end else begin
            n_out_min = {1'b0, low_q};
        end

        if ({1'b0, high_q} < r_cell_floor) begin
            n_out_max  = r_cell_floor;
            n_out_flag = 1'b1;
        end else if ({1'b0, high_q} > r_cell_ceiling) begin
            n_out_max  = r_cell_ceiling;
            n_out_flag = 1'b1;
        end else begin
            n_out_max = {1'b0, high_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_snap_valid) begin
            r_out_pack      <= n_out_pack;
            r_out_min       <= n_out_min;
            r_out_min_label <= label_of(r_snap.low_stack, r_snap.low_module);
            r_out_max       <= n_out_max;
            r_out_max_label <= label_of(r_snap.high_stack, r_snap.high_module);
            r_out_flag      <= n_out_flag;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_pack_volts         = r_out_pack;
    assign o_min_cell_decivolts = r_out_min;
    assign o_min_cell_label     = r_out_min_label;
    assign o_max_cell_decivolts = r_out_max;
    assign o_max_cell_label     = r_out_max_label;
    assign o_bounds_flag        = r_out_flag;

endmodule
`default_nettype wire

### hdl/cvsf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cell voltage summary frame checker
// Port-level checks on frame timing and command acceptance.
// ----------------------------------------------------------------------------
module cvsf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last_cell,
    input wire logic o_valid,
    input wire logic pready
);

    // a frame only follows an accepted last reading
    a_frame_has_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_last_cell, 3))
        else $error("frame strobe without a last reading three cycles before");

    // every last reading produces its frame
    a_frame_follows_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_cell) ##1 i_rst_n ##1 i_rst_n |=> o_valid)
        else $error("last reading produced no frame");

    // the block takes a transaction in every cycle
    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && pready)
        else $error("block stalled a transaction");

endmodule

bind cell_voltage_summary_frame_unit cvsf_checker u_cvsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_last_cell (i_last_cell),
    .o_valid     (o_valid),
    .pready      (pready)
);
`default_nettype wire

### dv/tb_cell_voltage_summary_frame_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell voltage summary frame unit - testbench
// Drives cell scans through the command port and predicts every summary
// frame: running min/max with first-cell-wins ties, truncating unit scaling,
// clamping to the configured bounds and the position label ROM. Bounds are
// rewritten over APB between phases, always with the block idle.
// ----------------------------------------------------------------------------
module tb_cell_voltage_summary_frame_unit;
    import cvsf_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Channel labels, row-major by stack then module
    localparam logic [0:35][7:0] CHANNEL_LABELS = {
        8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd91, 8'd6,  8'd7,  8'd8,  8'd9,  8'd10, 8'd92,
        8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd93, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd94,
        8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32
    };

    typedef struct packed {
        logic [15:0] pack_volts;
        logic [7:0]  min_decivolts;
        logic [7:0]  min_label;
        logic [7:0]  max_decivolts;
        logic [7:0]  max_label;
        logic        bounds_flag;
    } t_frame;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        start              = 1'b0;
    logic        busy;
    logic [15:0] i_cell_raw_voltage = '0;
    logic        i_cell_enabled     = 1'b0;
    logic [1:0]  i_stack_index      = '0;
    logic [3:0]  i_module_index     = '0;
    logic        i_last_cell        = 1'b0;
    logic [31:0] i_pack_raw_voltage = '0;
    logic        o_valid;
    logic [15:0] o_pack_volts;
    logic [7:0]  o_min_cell_decivolts;
    logic [7:0]  o_min_cell_label;
    logic [7:0]  o_max_cell_decivolts;
    logic [7:0]  o_max_cell_label;
    logic        o_bounds_flag;
    logic        psel               = 1'b0;
    logic        penable            = 1'b0;
    logic        pwrite             = 1'b0;
    logic [3:0]  paddr              = '0;
    logic [31:0] pwdata             = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the bounds and the running scan
    logic [15:0] cfg_pack_floor;
    logic [15:0] cfg_pack_ceiling;
    logic [7:0]  cfg_cell_floor;
    logic [7:0]  cfg_cell_ceiling;
    logic [15:0] scan_lowest;
    logic [15:0] scan_highest;
    logic [1:0]  low_stack;
    logic [3:0]  low_module;
    logic [1:0]  high_stack;
    logic [3:0]  high_module;

    t_frame expected_frames[$];
    int     readings_taken = 0;
    int     readings_seen  = 0;
    int     idle_cycles    = 0;
    int     errors         = 0;
    bit     gaps_on        = 1'b1;

    cell_voltage_summary_frame_unit i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cell_raw_voltage   (i_cell_raw_voltage),
        .i_cell_enabled       (i_cell_enabled),
        .i_stack_index        (i_stack_index),
        .i_module_index       (i_module_index),
        .i_last_cell          (i_last_cell),
        .i_pack_raw_voltage   (i_pack_raw_voltage),
        .o_valid              (o_valid),
        .o_pack_volts         (o_pack_volts),
        .o_min_cell_decivolts (o_min_cell_decivolts),
        .o_min_cell_label     (o_min_cell_label),
        .o_max_cell_decivolts (o_max_cell_decivolts),
        .o_max_cell_label     (o_max_cell_label),
        .o_bounds_flag        (o_bounds_flag),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] channel_label(input logic [1:0] stk,
                                                 input logic [3:0] mdl);
        if (stk >= 2'd3 || mdl >= 4'd12)
            return 8'd0;
        return CHANNEL_LABELS[stk * 12 + mdl];
    endfunction

    // {clamped flag, value}
    function automatic logic [32:0] clamp_to(input logic [31:0] v,
                                             input logic [31:0] lo,
                                             input logic [31:0] hi);
        if (v < lo)
            return {1'b1, lo};
        if (v > hi)
            return {1'b1, hi};
        return {1'b0, v};
    endfunction

    task automatic clear_scan();
        scan_lowest  = NO_VOLTAGE_LOW;
        scan_highest = '0;
        low_stack    = '0;
        low_module   = '0;
        high_stack   = '0;
        high_module  = '0;
    endtask

    task automatic track_reading(input logic [15:0] v, input logic en,
                                 input logic [1:0] stk, input logic [3:0] mdl,
                                 input logic last, input logic [31:0] pack);
        t_frame      frm;
        logic [32:0] pk;
        logic [32:0] lo;
        logic [32:0] hi;
        if (en && stk < STACKS && mdl < MODULES_PER_STACK) begin
            if (v < scan_lowest) begin
                scan_lowest = v;
                low_stack   = stk;
                low_module  = mdl;
            end
            if (v > scan_highest) begin
                scan_highest = v;
                high_stack   = stk;
                high_module  = mdl;
            end
        end
        if (last) begin
            pk = clamp_to(pack / 32'd10000, {16'd0, cfg_pack_floor}, {16'd0, cfg_pack_ceiling});
            lo = clamp_to({16'd0, scan_lowest} / 32'd1000, {24'd0, cfg_cell_floor},
                          {24'd0, cfg_cell_ceiling});
            hi = clamp_to({16'd0, scan_highest} / 32'd1000, {24'd0, cfg_cell_floor},
                          {24'd0, cfg_cell_ceiling});
            frm.pack_volts    = pk[15:0];
            frm.min_decivolts = lo[7:0];
            frm.min_label     = channel_label(low_stack, low_module);
            frm.max_decivolts = hi[7:0];
            frm.max_label     = channel_label(high_stack, high_module);
            frm.bounds_flag   = pk[32] | lo[32] | hi[32];
            expected_frames.push_back(frm);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Command port
    // ------------------------------------------------------------------------
    task automatic send_reading(input logic [15:0] v, input logic en,
                                input logic [1:0] stk, input logic [3:0] mdl,
                                input logic last, input logic [31:0] pack);
        while (gaps_on && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start              <= 1'b1;
        i_cell_raw_voltage <= v;
        i_cell_enabled     <= en;
        i_stack_index      <= stk;
        i_module_index     <= mdl;
        i_last_cell        <= last;
        i_pack_raw_voltage <= pack;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        readings_taken++;
        track_reading(v, en, stk, mdl, last, pack);
    endtask

    // Hold the sender until every frame is out, then let the pipeline settle
    task automatic wait_frames_out();
        start <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus returns to idle between transactions
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_PACK_FLOOR:   return {16'd0, cfg_pack_floor};
            REG_PACK_CEILING: return {16'd0, cfg_pack_ceiling};
            REG_CELL_FLOOR:   return {24'd0, cfg_cell_floor};
            REG_CELL_CEILING: return {24'd0, cfg_cell_ceiling};
            default:          return '0;
        endcase
    endfunction

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] rd;
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== register_value(idx)) begin
            $error("register %0d readback expected %0d actual %0d",
                   idx, register_value(idx), rd);
            errors++;
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_transfer(1'b1, idx, value, unused);
        case (idx)
            REG_PACK_FLOOR:   cfg_pack_floor   = value[15:0];
            REG_PACK_CEILING: cfg_pack_ceiling = value[15:0];
            REG_CELL_FLOOR:   cfg_cell_floor   = value[7:0];
            REG_CELL_CEILING: cfg_cell_ceiling = value[7:0];
            default: ;
        endcase
        check_register(idx);
    endtask

    task automatic set_bounds(input logic [31:0] pf, input logic [31:0] pc,
                              input logic [31:0] cf, input logic [31:0] cc);
        write_register(REG_PACK_FLOOR, pf);
        write_register(REG_PACK_CEILING, pc);
        write_register(REG_CELL_FLOOR, cf);
        write_register(REG_CELL_CEILING, cc);
    endtask

    // ------------------------------------------------------------------------
    // Frame checker and watchdog
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : frame_checker
        t_frame want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_frames.size() == 0) begin
                $error("frame with no scan pending: pack_volts %0d", o_pack_volts);
                errors++;
            end else begin
                want = expected_frames.pop_front();
                compare_field("pack_volts", want.pack_volts, o_pack_volts);
                compare_field("min_cell_decivolts", 16'(want.min_decivolts),
                              16'(o_min_cell_decivolts));
                compare_field("min_cell_label", 16'(want.min_label),
                              16'(o_min_cell_label));
                compare_field("max_cell_decivolts", 16'(want.max_decivolts),
                              16'(o_max_cell_decivolts));
                compare_field("max_cell_label", 16'(want.max_label),
                              16'(o_max_cell_label));
                compare_field("bounds_flag", 16'(want.bounds_flag), 16'(o_bounds_flag));
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_valid === 1'b1 || readings_taken != readings_seen) begin
            idle_cycles   = 0;
            readings_seen = readings_taken;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] cell_sample(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(25000, 43000));
            default: begin
                // few distinct values so that ties turn up often
                case ($urandom_range(0, 4))
                    0: return 16'd0;
                    1: return 16'd65535;
                    2: return 16'd30000;
                    3: return 16'd30999;
                    default: return 16'd31000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pack_sample();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return 32'($urandom_range(0, 700000000));
            default: return 32'($urandom_range(2000000, 5000000));
        endcase
    endfunction

    task automatic run_random_scan(output int count);
        int          len;
        int          vmode;
        bit          noise;
        logic        en;
        logic [1:0]  stk;
        logic [3:0]  mdl;
        logic        last;
        logic [31:0] pack;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        vmode = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
            noise = ($urandom_range(0, 99) < 10);
            en    = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) >= 5);
            stk   = noise ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 2));
            mdl   = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 11));
            last  = (i == len - 1);
            pack  = last ? pack_sample() : $urandom;
            send_reading(cell_sample(vmode), en, stk, mdl, last, pack);
        end
        count = len;
    endtask

    task automatic run_scans(input int n_items, input int pause_every);
        int sent;
        int since_pause;
        int n;
        sent        = 0;
        since_pause = 0;
        while (sent < n_items) begin
            run_random_scan(n);
            sent        += n;
            since_pause += n;
            if (pause_every > 0 && since_pause >= pause_every) begin
                wait_frames_out();
                since_pause = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_defaults();
        check_register(REG_PACK_FLOOR);
        check_register(REG_PACK_CEILING);
        check_register(REG_CELL_FLOOR);
        check_register(REG_CELL_CEILING);
    endtask

    // Scans with no tracked cell report the cleared extremes at stack 0 module 0
    task automatic test_empty_scans();
        send_reading(16'd12345, 1'b0, 2'd1, 4'd3, 1'b1, 32'd3700000);
        send_reading(16'd100, 1'b1, 2'd3, 4'd0, 1'b1, 32'd0);
        send_reading(16'd100, 1'b1, 2'd0, 4'd12, 1'b1, 32'hFFFF_FFFF);
        wait_frames_out();
    endtask

    task automatic test_directed_frames();
        // ties keep the first cell; unused-channel labels
        send_reading(16'd40000, 1'b1, 2'd0, 4'd5, 1'b0, 32'd0);
        send_reading(16'd40000, 1'b1, 2'd1, 4'd5, 1'b0, 32'd0);
        send_reading(16'd20000, 1'b1, 2'd0, 4'd11, 1'b0, 32'd0);
        send_reading(16'd20000, 1'b1, 2'd1, 4'd11, 1'b1, 32'd0);
        // voltage extremes, pack beyond 16 bits after scaling
        send_reading(16'd0, 1'b1, 2'd1, 4'd5, 1'b0, 32'd0);
        send_reading(16'd65535, 1'b1, 2'd1, 4'd11, 1'b1, 32'hFFFF_FFFF);
        // disabled and out-of-range cells are not tracked
        send_reading(16'd65535, 1'b0, 2'd2, 4'd0, 1'b0, 32'd0);
        send_reading(16'd1, 1'b1, 2'd3, 4'd1, 1'b0, 32'd0);
        send_reading(16'd2, 1'b1, 2'd2, 4'd12, 1'b0, 32'd0);
        send_reading(16'd3, 1'b1, 2'd2, 4'd15, 1'b0, 32'd0);
        send_reading(16'd30000, 1'b1, 2'd2, 4'd11, 1'b1, 32'd655359999);
        // the last reading itself sets the maximum; pack just above the ceiling
        send_reading(16'd35000, 1'b1, 2'd2, 4'd0, 1'b0, 32'd0);
        send_reading(16'd36000, 1'b1, 2'd2, 4'd1, 1'b1, 32'd655360000);
        wait_frames_out();
    endtask

    task automatic test_clamp_settings();
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_bounds(0, 65535, 0, 255);
                1: set_bounds(0, 0, 0, 0);
                2: set_bounds(65535, 65535, 255, 255);
                3: set_bounds(300, 450, 30, 42);
                4: set_bounds(450, 300, 42, 30);     // floor above ceiling
                5: set_bounds(65535, 0, 255, 0);
                default: set_bounds($urandom, $urandom, $urandom, $urandom);
            endcase
            run_scans(150, 0);
            wait_frames_out();
        end
        set_bounds(0, 65535, 0, 255);
    endtask

    task automatic test_random_scans();
        set_bounds($urandom_range(0, 400), $urandom_range(200, 65535),
                   $urandom_range(0, 35), $urandom_range(30, 255));
        // pause the sender now and then until every frame is back
        run_scans(650, 300);
        wait_frames_out();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_scans(200, 0);
        wait_frames_out();
        gaps_on = 1'b1;
    endtask

    initial begin
        cfg_pack_floor   = '0;
        cfg_pack_ceiling = PACK_CEILING_INIT;
        cfg_cell_floor   = '0;
        cfg_cell_ceiling = CELL_CEILING_INIT;
        clear_scan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_empty_scans();
        test_directed_frames();
        test_clamp_settings();
        test_random_scans();
        test_back_to_back();

        wait_frames_out();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
